// File: design/shsr_pkg.sv
// shared types and constants for the staged seat heater regulator
package shsr_pkg;

    localparam int ADC_W      = 12;
    localparam int TEMP_W     = 6;
    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int LEVEL_W    = 2;
    localparam int STAGE_W    = 2;
    localparam int HOLD_W     = 3;
    localparam int LED_W      = 3;

    // full span of the scaled temperature in degrees
    localparam logic [TEMP_W-1:0] TEMP_SPAN = 6'd45;

    // shortfall thresholds for the medium and high stages
    localparam logic [TEMP_W-1:0] DIFF_HIGH   = 6'd10;
    localparam logic [TEMP_W-1:0] DIFF_MEDIUM = 6'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT_LOW    = 3'd0,
        REG_SETPOINT_MEDIUM = 3'd1,
        REG_SETPOINT_HIGH   = 3'd2,
        REG_SAFE_MIN        = 3'd3,
        REG_SAFE_MAX        = 3'd4,
        REG_LOW_ON_DIFF     = 3'd5,
        REG_LOW_HOLD_DIFF   = 3'd6
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_SETPOINT_LOW    = 6'd25;
    localparam logic [CFG_W-1:0] RST_SETPOINT_MEDIUM = 6'd30;
    localparam logic [CFG_W-1:0] RST_SETPOINT_HIGH   = 6'd35;
    localparam logic [CFG_W-1:0] RST_SAFE_MIN        = 6'd5;
    localparam logic [CFG_W-1:0] RST_SAFE_MAX        = 6'd40;
    localparam logic [CFG_W-1:0] RST_LOW_ON_DIFF     = 6'd4;
    localparam logic [CFG_W-1:0] RST_LOW_HOLD_DIFF   = 6'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_OFF    = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW    = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd2;

    localparam logic [STAGE_W-1:0] STAGE_OFF    = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_LOW    = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_MEDIUM = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_HIGH   = 2'd3;

    localparam logic [LED_W-1:0] LED_NONE   = 3'd0;
    localparam logic [LED_W-1:0] LED_BLUE   = 3'd1;
    localparam logic [LED_W-1:0] LED_GREEN  = 3'd2;
    localparam logic [LED_W-1:0] LED_LOW    = 3'd3;
    localparam logic [LED_W-1:0] LED_RED    = 3'd4;

    typedef struct packed {
        logic              seat;
        logic [ADC_W-1:0]  adc_sample;
        logic              press_first;
        logic              press_confirm;
    } t_in_item;

    typedef struct packed {
        logic               seat_out;
        logic [TEMP_W-1:0]  temperature;
        logic [LEVEL_W-1:0] level;
        logic [STAGE_W-1:0] heater_stage;
        logic               fault;
        logic [LED_W-1:0]   led_rgb;
    } t_out_item;

endpackage

// File: design/shsr_scale.sv
// converts a raw converter sample to whole degrees, saturated at the span
module shsr_scale #(
    parameter int ADC_FULL_SCALE = 4095
) (
    input  logic [shsr_pkg::ADC_W-1:0]  i_adc,
    output logic [shsr_pkg::TEMP_W-1:0] o_temp
);
    import shsr_pkg::*;

    // adc * span fits in PROD_W bits
    localparam int PROD_W  = ADC_W + TEMP_W;
    localparam int FS_LOG  = $clog2(ADC_FULL_SCALE);
    localparam int SHIFT   = PROD_W + FS_LOG;
    localparam int RECIP_W = PROD_W + 1;
    localparam int FULL_W  = PROD_W + RECIP_W;
    // rounded-up reciprocal: exact floor quotient for every PROD_W-bit dividend
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    logic [PROD_W-1:0] w_scaled;
    logic [FULL_W-1:0] w_full;
    logic [FULL_W-1:0] w_quot;

    assign w_scaled = PROD_W'(i_adc) * PROD_W'(TEMP_SPAN);
    assign w_full   = FULL_W'(w_scaled) * FULL_W'(RECIP);
    assign w_quot   = w_full >> SHIFT;
    assign o_temp   = (w_quot > FULL_W'(TEMP_SPAN)) ? TEMP_SPAN : w_quot[TEMP_W-1:0];

endmodule

// File: design/seat_heater_staged_regulator.sv
// top level of the staged seat heater regulator
// Staged seat heater regulator for up to two seats.
// Input channel: i_in_valid / o_in_stall with i_in_data, one control tick of
// one seat per transfer (seat number, raw sample, two button samples).
// Output channel: o_out_valid / i_out_stall with o_out_data, exactly one
// result per tick, in tick order.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_index
// (setpoints, safe window, low stage thresholds); write only while idle.
// A tick is registered in the input register on transfer, and its result is
// registered in the output register once the decision stage proceeds.
// Throughput: one tick per cycle while the receiver does not stall; the
// per-seat level, stage and hold-off state is read and rewritten with the
// decision itself, so ticks for the same seat may follow each other directly.
// Reset clears both seats to level off, heater off, no hold-off, restores
// the register defaults and empties the pipeline.
// When the receiver stalls, the result register holds; the input register
// then fills and o_in_stall rises until the result is taken.
module seat_heater_staged_regulator #(
    parameter int ADC_FULL_SCALE = 4095,
    parameter int HOLDOFF_TICKS  = 5,
    parameter int NUM_SEATS      = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  shsr_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output shsr_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [shsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [shsr_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import shsr_pkg::*;

    logic [CFG_W-1:0] r_sp_low, r_sp_medium, r_sp_high;
    logic [CFG_W-1:0] r_safe_min, r_safe_max, r_low_on, r_low_hold;

    logic [LEVEL_W-1:0] r_level [NUM_SEATS];
    logic [STAGE_W-1:0] r_stage [NUM_SEATS];
    logic [HOLD_W-1:0]  r_hold  [NUM_SEATS];

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic w_in_fire;
    logic w_proc;
    logic w_present;
    logic w_pressed;

    logic [TEMP_W-1:0]  w_temp;
    logic [LEVEL_W-1:0] w_cur_level;
    logic [STAGE_W-1:0] w_prev_stage;
    logic [HOLD_W-1:0]  w_cur_hold;
    logic [CFG_W-1:0]   w_setpoint;
    logic [TEMP_W-1:0]  w_diff;
    logic [CFG_W-1:0]   w_low_need;

    logic [LEVEL_W-1:0] n_level;
    logic [HOLD_W-1:0]  n_hold;
    logic [STAGE_W-1:0] n_stage;
    logic               n_fault;
    logic [LED_W-1:0]   n_led;
    t_out_item          n_out;

    // ---------------- handshake ----------------
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_proc      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_proc;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_low    <= RST_SETPOINT_LOW;
            r_sp_medium <= RST_SETPOINT_MEDIUM;
            r_sp_high   <= RST_SETPOINT_HIGH;
            r_safe_min  <= RST_SAFE_MIN;
            r_safe_max  <= RST_SAFE_MAX;
            r_low_on    <= RST_LOW_ON_DIFF;
            r_low_hold  <= RST_LOW_HOLD_DIFF;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SETPOINT_LOW:    r_sp_low    <= i_cfg_wdata;
                REG_SETPOINT_MEDIUM: r_sp_medium <= i_cfg_wdata;
                REG_SETPOINT_HIGH:   r_sp_high   <= i_cfg_wdata;
                REG_SAFE_MIN:        r_safe_min  <= i_cfg_wdata;
                REG_SAFE_MAX:        r_safe_max  <= i_cfg_wdata;
                REG_LOW_ON_DIFF:     r_low_on    <= i_cfg_wdata;
                REG_LOW_HOLD_DIFF:   r_low_hold  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- decision ----------------
    shsr_scale #(
        .ADC_FULL_SCALE(ADC_FULL_SCALE)
    ) u_scale (
        .i_adc  (r_in.adc_sample),
        .o_temp (w_temp)
    );

    assign w_present = (int'(r_in.seat) < NUM_SEATS);
    assign w_pressed = r_in.press_first && r_in.press_confirm;

    always_comb begin
        if (w_present) begin
            w_cur_level  = r_level[r_in.seat];
            w_prev_stage = r_stage[r_in.seat];
            w_cur_hold   = r_hold[r_in.seat];
        end else begin
            w_cur_level  = LEVEL_OFF;
            w_prev_stage = STAGE_OFF;
            w_cur_hold   = '0;
        end
    end

    // hold-off first, then the press steps the level
    always_comb begin
        n_level = w_cur_level;
        n_hold  = w_cur_hold;
        if (w_cur_hold != '0) begin
            n_hold = w_cur_hold - HOLD_W'(1);
        end else if (w_pressed) begin
            n_level = w_cur_level + LEVEL_W'(1);
            n_hold  = HOLD_W'(HOLDOFF_TICKS);
        end
    end

    always_comb begin
        case (n_level)
            LEVEL_LOW:    w_setpoint = r_sp_low;
            LEVEL_MEDIUM: w_setpoint = r_sp_medium;
            default:      w_setpoint = r_sp_high;
        endcase
    end

    assign w_diff     = w_setpoint - w_temp;
    assign w_low_need = (w_prev_stage != STAGE_OFF) ? r_low_hold : r_low_on;

    always_comb begin
        n_stage = STAGE_OFF;
        n_fault = 1'b0;
        n_led   = LED_NONE;
        if (!w_present) begin
            n_stage = STAGE_OFF;
        end else if (w_temp < r_safe_min || w_temp > r_safe_max) begin
            n_fault = 1'b1;
            n_led   = LED_RED;
        end else if (n_level != LEVEL_OFF && w_setpoint > w_temp) begin
            if (w_diff >= DIFF_HIGH) begin
                n_stage = STAGE_HIGH;
                n_led   = LED_GREEN;
            end else if (w_diff >= DIFF_MEDIUM) begin
                n_stage = STAGE_MEDIUM;
                n_led   = LED_BLUE;
            end else if (w_diff >= w_low_need) begin
                n_stage = STAGE_LOW;
                n_led   = LED_LOW;
            end
        end
    end

    always_comb begin
        n_out.seat_out     = r_in.seat;
        n_out.temperature  = w_temp;
        n_out.level        = w_present ? n_level : LEVEL_OFF;
        n_out.heater_stage = n_stage;
        n_out.fault        = n_fault;
        n_out.led_rgb      = n_led;
    end

    // ---------------- control and seat state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SEATS; i++) begin
                r_level[i] <= LEVEL_OFF;
                r_stage[i] <= STAGE_OFF;
                r_hold[i]  <= '0;
            end
        end else begin
            if (w_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_proc && w_present) begin
                r_level[r_in.seat] <= n_level;
                r_stage[r_in.seat] <= n_stage;
                r_hold[r_in.seat]  <= n_hold;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in <= i_in_data;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_rst_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_fault_heater_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.fault |-> o_out_data.heater_stage == STAGE_OFF)
        else $error("heater driven during fault");

    a_stage_needs_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.heater_stage != STAGE_OFF
            |-> o_out_data.level != LEVEL_OFF)
        else $error("heater on with level off");

    a_low_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.led_rgb == LED_LOW)
            == (o_out_data.heater_stage == STAGE_LOW)))
        else $error("led pattern does not match low stage");
`endif

endmodule
